/* sv/i2c_bit_level_master_unit_defines.svh */
// Assertion macros shared by the bit engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define I2CBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define I2CBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/i2cbm_pkg.sv */
`timescale 1ns / 1ps

package i2cbm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_TX_BYTE = 3'd3,
        CMD_RX_BYTE = 3'd4,
        CMD_TX_ACK  = 3'd5,
        CMD_RX_ACK  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        OP_SDA  = 2'd0,
        OP_SCL  = 2'd1,
        OP_READ = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     val;
    } op_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic       rx_ack;
    } res_t;

    localparam int unsigned SLOT_W = 16;
    localparam logic [SLOT_W-1:0] SLOT_TICKS_RST = 16'd2;
    localparam logic RX_ACK_RST = 1'b1;

    // Number of pin slots in each command's sequence.
    function automatic logic [4:0] seq_len(cmd_t cmd);
        logic [4:0] len;
        case (cmd)
            CMD_START:   len = 5'd4;
            CMD_STOP:    len = 5'd3;
            CMD_TX_BYTE: len = 5'd24;
            CMD_RX_BYTE: len = 5'd25;
            CMD_TX_ACK:  len = 5'd3;
            CMD_RX_ACK:  len = 5'd4;
            default:     len = 5'd1;
        endcase
        return len;
    endfunction

    // Pin operation for one slot; bitp is the bit counted from the MSB, ph
    // its place in a bit (TX: data, SCL up, down; RX: SCL up, read, down).
    function automatic op_t seq_op(cmd_t cmd, logic [4:0] step, logic [1:0] ph,
                                   logic [2:0] bitp, logic [7:0] shd);
        op_t op;
        op.kind = OP_SDA;
        op.val  = 1'b0;
        case (cmd)
            CMD_START:
            begin
                op.kind = step[0] ? OP_SCL : OP_SDA;
                op.val  = ~step[1];
            end
            CMD_STOP:
            begin
                op.kind = (step == 5'd1) ? OP_SCL : OP_SDA;
                op.val  = (step != 5'd0);
            end
            CMD_TX_BYTE:
            begin
                if (ph == 2'd0)
                begin
                    op.kind = OP_SDA;
                    op.val  = shd[3'd7 - bitp];
                end
                else
                begin
                    op.kind = OP_SCL;
                    op.val  = (ph == 2'd1);
                end
            end
            CMD_RX_BYTE:
            begin
                if (step == 5'd0)
                begin
                    op.kind = OP_SDA;
                    op.val  = 1'b1;
                end
                else if (ph == 2'd1)
                begin
                    op.kind = OP_READ;
                end
                else
                begin
                    op.kind = OP_SCL;
                    op.val  = (ph == 2'd0);
                end
            end
            CMD_TX_ACK:
            begin
                if (step == 5'd0)
                begin
                    op.kind = OP_SDA;
                    op.val  = shd[0];
                end
                else
                begin
                    op.kind = OP_SCL;
                    op.val  = (step == 5'd1);
                end
            end
            CMD_RX_ACK:
            begin
                if (step == 5'd0)
                begin
                    op.kind = OP_SDA;
                    op.val  = 1'b1;
                end
                else if (step == 5'd2)
                begin
                    op.kind = OP_READ;
                end
                else
                begin
                    op.kind = OP_SCL;
                    op.val  = (step == 5'd1);
                end
            end
            default:
            begin
                op.kind = OP_SDA;
                op.val  = 1'b0;
            end
        endcase
        return op;
    endfunction

endpackage

/* sv/i2cbm_engine.sv */
`timescale 1ns / 1ps

`include "i2c_bit_level_master_unit_defines.svh"

module i2cbm_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  i2cbm_pkg::tick_t            tick,
    input  logic [i2cbm_pkg::SLOT_W-1:0] slot_ticks,
    output i2cbm_pkg::res_t             res
);
    import i2cbm_pkg::*;

    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    cmd_t              cmd_reg, cmd_next;
    logic [7:0]        shift_reg, shift_next;
    logic [4:0]        step_reg, step_next;
    logic [1:0]        ph_reg, ph_next;
    logic [2:0]        bit_reg, bit_next;
    logic [SLOT_W-1:0] tick_reg, tick_next;
    logic [7:0]        rx_byte_reg, rx_byte_next;
    logic              rx_ack_reg, rx_ack_next;

    cmd_t              cmd_a;
    logic [7:0]        shift_a;
    logic [4:0]        step_a;
    logic [1:0]        ph_a;
    logic [2:0]        bit_a;
    logic [SLOT_W-1:0] tick_a;
    logic [SLOT_W-1:0] slots;
    logic [4:0]        step_inc;
    logic              ready;
    logic              done;
    op_t               op;

    assign slots = (slot_ticks == '0) ? {{(SLOT_W-1){1'b0}}, 1'b1} : slot_ticks;

    always_comb
    begin
        // Command acceptance happens first; its first slot runs in the same tick.
        cmd_a   = cmd_reg;
        shift_a = shift_reg;
        step_a  = step_reg;
        ph_a    = ph_reg;
        bit_a   = bit_reg;
        tick_a  = tick_reg;
        ready   = 1'b0;
        if ((cmd_reg == CMD_NONE) && (tick.action inside {[CMD_START:CMD_RX_ACK]}))
        begin
            cmd_a = cmd_t'(tick.action);
            if (tick.action == CMD_TX_BYTE)
                shift_a = tick.tx_byte;
            else if (tick.action == CMD_TX_ACK)
                shift_a = {7'd0, tick.ack_level};
            else
                shift_a = 8'd0;
            step_a = '0;
            ph_a   = '0;
            bit_a  = '0;
            tick_a = '0;
            ready  = 1'b1;
        end

        op       = seq_op(cmd_a, step_a, ph_a, bit_a, shift_a);
        step_inc = step_a + 5'd1;

        cmd_next     = cmd_a;
        shift_next   = shift_a;
        step_next    = step_a;
        ph_next      = ph_a;
        bit_next     = bit_a;
        tick_next    = tick_a;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_byte_next = rx_byte_reg;
        rx_ack_next  = rx_ack_reg;
        done         = 1'b0;

        if (cmd_a != CMD_NONE)
        begin
            if (tick_a == '0)
            begin
                case (op.kind)
                    OP_SDA:  sda_next = op.val;
                    OP_SCL:  scl_next = op.val;
                    OP_READ:
                    begin
                        if (cmd_a == CMD_RX_BYTE)
                        begin
                            if (tick.sda_in)
                                shift_next[3'd7 - bit_a] = 1'b1;
                        end
                        else
                        begin
                            rx_ack_next = tick.sda_in;
                        end
                    end
                    default: ;
                endcase
            end

            if (({1'b0, tick_a} + {{SLOT_W{1'b0}}, 1'b1}) >= {1'b0, slots})
            begin
                tick_next = '0;
                step_next = step_inc;
                // The leading release slot of a receive byte sits outside the bit phases.
                if (!((cmd_a == CMD_RX_BYTE) && (step_a == 5'd0)))
                begin
                    if (ph_a == 2'd2)
                    begin
                        ph_next  = 2'd0;
                        bit_next = bit_a + 3'd1;
                    end
                    else
                    begin
                        ph_next = ph_a + 2'd1;
                    end
                end
                if (step_inc >= seq_len(cmd_a))
                begin
                    if (cmd_a == CMD_RX_BYTE)
                        rx_byte_next = shift_next;
                    done      = 1'b1;
                    cmd_next  = CMD_NONE;
                    step_next = '0;
                    ph_next   = '0;
                    bit_next  = '0;
                end
            end
            else
            begin
                tick_next = tick_a + {{(SLOT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            cmd_reg     <= CMD_NONE;
            shift_reg   <= '0;
            step_reg    <= '0;
            ph_reg      <= '0;
            bit_reg     <= '0;
            tick_reg    <= '0;
            rx_byte_reg <= '0;
            rx_ack_reg  <= RX_ACK_RST;
        end
        else if (en)
        begin
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            cmd_reg     <= cmd_next;
            shift_reg   <= shift_next;
            step_reg    <= step_next;
            ph_reg      <= ph_next;
            bit_reg     <= bit_next;
            tick_reg    <= tick_next;
            rx_byte_reg <= rx_byte_next;
            rx_ack_reg  <= rx_ack_next;
        end
    end

    assign res.scl_out   = scl_next;
    assign res.sda_out   = sda_next;
    assign res.ready_res = ready;
    assign res.done_res  = done;
    assign res.rx_data   = rx_byte_next;
    assign res.rx_ack    = rx_ack_next;

    `I2CBM_ASSERT_IMP(a_idle_counters_clear, cmd_reg == CMD_NONE, (step_reg == '0) && (tick_reg == '0) && (ph_reg == '0) && (bit_reg == '0), "idle engine holds stale slot counters")
    `I2CBM_ASSERT_IMP(a_step_in_sequence, cmd_reg != CMD_NONE, step_reg < seq_len(cmd_reg), "slot step ran past the end of the sequence")
    `I2CBM_ASSERT_IMP(a_phase_bound, 1'b1, ph_reg != 2'd3, "bit phase counter out of range")
    `I2CBM_ASSERT_NXT(a_done_goes_idle, en && done, cmd_reg == CMD_NONE, "engine still busy after completing a command")

endmodule

/* sv/i2c_bit_level_master_unit.sv */
`timescale 1ns / 1ps

// I2C master bit engine. Each word on the tick channel is one timer tick:
// the sampled SDA level and, while the engine is idle, an optional command
// (start, stop, send byte, receive byte, send ack, receive ack). Each tick
// word yields exactly one result word on the res channel, carrying the SCL
// and SDA levels to drive, the ready and done pulses and the last received
// byte and acknowledge bit.
// The cfg channel writes slot_ticks, the number of ticks per pin slot; it
// is always ready and should only be written while no command runs.
// A tick word passes through the input register, then through the step
// logic into the result register, before the result is offered.
// Throughput is one tick word per cycle while no full result register
// is held by res_stall.
// When res_stall holds a full result register, tick_stall rises in the same
// cycle and the whole pipeline freezes; nothing is dropped.
// Reset releases both lines, goes idle, sets slot_ticks to 2 and rx_ack to 1.
module i2c_bit_level_master_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_valid,
    output logic                         tick_stall,
    input  i2cbm_pkg::tick_t             tick,
    output logic                         res_valid,
    input  logic                         res_stall,
    output i2cbm_pkg::res_t              res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [i2cbm_pkg::SLOT_W-1:0] cfg_data
);
    import i2cbm_pkg::*;

    logic              adv;
    logic              in_valid_reg;
    tick_t             in_word_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              step_res;
    logic [SLOT_W-1:0] slot_ticks_reg;

    assign adv        = !(res_valid_reg && res_stall);
    assign tick_stall = !adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_ticks_reg <= SLOT_TICKS_RST;
        else if (cfg_valid && cfg_ready)
            slot_ticks_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= tick_valid;
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_word_reg <= tick;
            if (in_valid_reg)
                res_reg <= step_res;
        end
    end

    i2cbm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv && in_valid_reg),
        .tick       (in_word_reg),
        .slot_ticks (slot_ticks_reg),
        .res        (step_res)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
